FILE: hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and fixed constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Field widths fixed by the interface
  localparam int VC_WIDTH  = 7;
  localparam int IDX_WIDTH = 6;

  // Reset value of the vertex count register
  localparam logic [VC_WIDTH-1:0] VC_RESET = 7'd3;

  // Register word index of the vertex count register
  localparam logic REG_VERTEX_COUNT = 1'b0;

  // Request kinds carried on tuser
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TEST  = 1'b1
  } action_t;

  // Control that travels with each vertex read into the edge unit
  typedef struct packed {
    logic valid;  // read data lands this cycle
    logic prime;  // vertex only seeds the previous-vertex register
    logic last;   // closing edge of the polygon
  } edge_ctrl_t;

  // Per-edge outcome returned by the edge unit
  typedef struct packed {
    logic valid;  // one edge finished
    logic flip;   // edge crosses the ray: toggle parity
    logic last;   // closing edge of the polygon
  } edge_flip_t;

endpackage

FILE: hdl/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Even-odd ray-casting point-in-polygon test over a loadable vertex table.
//
//   channel | dir | handshake          | content
//   s_*     | in  | s_tvalid/s_tready  | vertex write or point query
//   m_*     | out | m_tvalid/m_tready  | inside flag, one per query
//   apb     | in  | psel/penable/pready| vertex_count register at 0x0
//
// During a query the sequencer reads one vertex per cycle from the
// single table read port and the edge unit finishes one edge per cycle
// behind it. Reset idles the sequencer, clears the output valid flag
// and sets vertex_count to VC_RESET (3); the vertex table is not cleared
// and must be written before it is queried. Input is held off during a
// query and while an unclaimed result would block the next one.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: vertex_index, vertex_x, vertex_y, point_x, point_y (low to high)
  input  logic [((pip_pkg::IDX_WIDTH + 4 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: action
  input  logic        s_tuser,
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: inside_res
  output logic [7:0]  m_tdata,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pip_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int NB    = $clog2(MAX_VERTICES + 1);
  localparam int NW    = (NB > VC_WIDTH) ? NB : VC_WIDTH;
  localparam int X_LO  = IDX_WIDTH;
  localparam int Y_LO  = X_LO + CW;
  localparam int PX_LO = Y_LO + CW;
  localparam int PY_LO = PX_LO + CW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t               state;
  logic [VC_WIDTH-1:0]  vertex_count;
  logic [NW-1:0]        n_eff, n_last, vc_ext, idx;
  logic signed [CW-1:0] qx, qy;
  logic                 parity;
  logic                 out_valid, out_res;

  logic                 accept, slot_ok, wr_en;
  logic [IDX_WIDTH-1:0] in_index;
  logic signed [CW-1:0] in_vx, in_vy;
  logic [2*CW-1:0]      rd_data;
  logic [AW-1:0]        rd_addr;
  edge_ctrl_t           issue, rd_ctrl;
  edge_flip_t           flip;

  // Unpack the request
  assign in_index = s_tdata[IDX_WIDTH-1:0];
  assign in_vx    = s_tdata[X_LO +: CW];
  assign in_vy    = s_tdata[Y_LO +: CW];

  // Clamp the vertex count to the table depth
  assign vc_ext = NW'(vertex_count);
  assign n_eff  = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;
  assign n_last = n_eff - NW'(1);

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign slot_ok  = 32'(in_index) < MAX_VERTICES;
  assign wr_en    = accept && (s_tuser == ACT_WRITE) && slot_ok;

  // Issue vertex reads: seed with the last vertex, then walk from slot 0
  always_comb begin
    issue   = '0;
    rd_addr = idx[AW-1:0];
    unique case (state)
      ST_PRIME: begin
        issue.valid = 1'b1;
        issue.prime = 1'b1;
        rd_addr     = n_last[AW-1:0];
      end
      ST_WALK: begin
        issue.valid = 1'b1;
        issue.last  = (idx == n_last);
      end
      ST_IDLE, ST_DRAIN: begin
        issue = '0;
      end
      default: begin
        issue = '0;
      end
    endcase
  end

  pip_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * CW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_index)),
    .wr_data ({in_vy, in_vx}),
    .rd_en   (issue.valid),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Align read control with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl <= '0;
    end else begin
      rd_ctrl <= issue;
    end
  end

  pip_edge_unit #(
    .CW (CW)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rd_ctrl),
    .vx   (rd_data[CW-1:0]),
    .vy   (rd_data[2*CW-1:CW]),
    .px   (qx),
    .py   (qy),
    .flip (flip)
  );

  // Sequencer and parity accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      parity    <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == ACT_TEST)) begin
            idx    <= '0;
            parity <= 1'b0;
            if (n_eff == '0) begin
              out_valid <= 1'b1;
              out_res   <= 1'b0;
            end else begin
              state <= ST_PRIME;
            end
          end
        end
        ST_PRIME: begin
          state <= ST_WALK;
        end
        ST_WALK: begin
          idx <= idx + NW'(1);
          if (idx == n_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (flip.valid && flip.last) begin
            state     <= ST_IDLE;
            out_valid <= 1'b1;
            out_res   <= parity ^ flip.flip;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (flip.valid) begin
        parity <= parity ^ flip.flip;
      end
    end
  end

  // Latch the query point
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == ACT_TEST)) begin
      qx <= s_tdata[PX_LO +: CW];
      qy <= s_tdata[PY_LO +: CW];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res};

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[VC_WIDTH-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VERTEX_COUNT: prdata = 32'(vertex_count);
      default:          prdata = '0;
    endcase
  end

  // Edge results appear only while a query runs
  a_flip_in_query: assert property (@(posedge clk) disable iff (rst)
    flip.valid |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("edge result outside a query");

  // A query never starts over an unclaimed result
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_tuser == ACT_TEST)) |-> (!out_valid || m_tready))
    else $error("query accepted while result blocked");

  // The walk stays inside the used vertices
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (idx < n_eff))
    else $error("walk index past vertex count");

  // The closing edge posts the result and frees the sequencer
  a_close: assert property (@(posedge clk) disable iff (rst)
    (flip.valid && flip.last) |=> (state == ST_IDLE && out_valid))
    else $error("closing edge did not post a result");

endmodule

FILE: hdl/pip_vertex_mem.sv
// ----------------------------------------------------------------------------
// pip_vertex_mem
// Vertex table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_vertex_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry into the output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Edge evaluator: one polygon edge per cycle through three stages
// (differences, cross products, compare) giving a parity toggle per edge.
// ----------------------------------------------------------------------------
module pip_edge_unit #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pip_pkg::edge_ctrl_t   ctrl,
  input  logic signed [CW-1:0]  vx,
  input  logic signed [CW-1:0]  vy,
  input  logic signed [CW-1:0]  px,
  input  logic signed [CW-1:0]  py,
  output pip_pkg::edge_flip_t   flip
);
  import pip_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [CW-1:0] prev_x, prev_y;

  logic                 s1_valid, s1_last;
  logic signed [DW-1:0] s1_dxp, s1_dy, s1_dx, s1_dpy;
  logic                 s1_straddle, s1_dypos;

  logic                 s2_valid, s2_last;
  logic signed [PW-1:0] s2_lhs, s2_rhs;
  logic                 s2_straddle, s2_dypos;

  logic                 hit;

  // Hold the previous vertex of the walk
  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prev_x <= vx;
      prev_y <= vy;
    end
  end

  // Stage 1: coordinate differences and straddle test
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= ctrl.valid && !ctrl.prime;
      s1_last  <= ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_dxp      <= DW'(px) - DW'(vx);
    s1_dy       <= DW'(prev_y) - DW'(vy);
    s1_dx       <= DW'(prev_x) - DW'(vx);
    s1_dpy      <= DW'(py) - DW'(vy);
    s1_straddle <= (vy > py) != (prev_y > py);
    s1_dypos    <= prev_y > vy;
  end

  // Stage 2: both cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s2_lhs      <= s1_dxp * s1_dy;
    s2_rhs      <= s1_dx * s1_dpy;
    s2_straddle <= s1_straddle;
    s2_dypos    <= s1_dypos;
  end

  // Stage 3: compare in the order set by the sign of dy
  assign hit = s2_dypos ? (s2_lhs < s2_rhs) : (s2_rhs < s2_lhs);

  assign flip.valid = s2_valid;
  assign flip.flip  = s2_straddle && hit;
  assign flip.last  = s2_last;

endmodule
